/* rtl/wbu_pkg.sv */
// Package for the watchpoint and breakpoint unit: beat payloads, operation codes,
// the tokens that walk the cell chains and the control group for the breakpoint cells.
// No dependencies.
package wbu_pkg;

  typedef enum logic [2:0] {
    ACT_CLEAR  = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_ACCESS = 3'd3,
    ACT_PC     = 3'd4
  } action_t;

  localparam logic [3:0] PT_BREAK_SW = 4'd0;
  localparam logic [3:0] PT_BREAK_HW = 4'd1;
  localparam logic [3:0] PT_WRITE    = 4'd2;
  localparam logic [3:0] PT_READ     = 4'd3;
  localparam logic [3:0] PT_ACCESS   = 4'd4;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_ZERO_LEN    = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
  localparam logic [1:0] ST_FULL        = 2'd3;

  localparam logic [5:0] BITS_BYTE = 6'd8;
  localparam logic [5:0] BITS_HALF = 6'd16;
  localparam logic [5:0] BITS_WORD = 6'd32;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  point_type;
    logic [31:0] point_address;
    logic [31:0] point_length;
    logic [31:0] access_address;
    logic [5:0]  access_bits;
    logic        is_write;
    logic [31:0] pc_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        at_breakpoint;
    logic        hit_valid;
    logic        hit_was_read;
    logic [31:0] hit_address;
  } out_item_t;

  typedef enum logic [1:0] {
    BOP_NOP,
    BOP_INS,
    BOP_REM,
    BOP_CHK
  } brk_op_t;

  typedef struct packed {
    logic        active;
    brk_op_t     op;
    logic [31:0] addr;
    logic        found;
    logic        free_seen;
  } brk_tok_t;

  typedef struct packed {
    logic commit;
    logic finish;
  } brk_ctl_t;

  typedef enum logic [1:0] {
    WOP_NOP,
    WOP_INS,
    WOP_REM,
    WOP_BUS
  } wch_op_t;

  typedef struct packed {
    logic        active;
    wch_op_t     op;
    logic [31:0] start;
    logic [31:0] len;
    logic        on_w;
    logic        on_r;
    logic [31:0] acc_addr;
    logic [31:0] acc_end;
    logic        is_wr;
    logic        claimed;
  } wch_tok_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_RESULT
  } state_t;

endpackage

/* rtl/wbu_stream_if.sv */
// Valid/ready channel carrying one payload per beat.
// The payload type is supplied by the instantiating level, normally from wbu_pkg.
interface wbu_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/wbu_brk_cell.sv */
// One breakpoint slot of the breakpoint cell chain.
// Depends on wbu_pkg for the token and control types.
module wbu_brk_cell
  import wbu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  brk_tok_t    tok_in,
  input  brk_ctl_t    ctl,
  input  logic [31:0] wr_addr,
  output brk_tok_t    tok_out
);

  logic [31:0] slot_addr;
  logic        slot_valid;
  logic        pending;
  logic        hit;
  logic        free;
  brk_tok_t    tok_next;

  always_comb begin
    hit                = tok_in.active && slot_valid && (slot_addr == tok_in.addr);
    free               = tok_in.active && !slot_valid;
    tok_next           = tok_in;
    tok_next.found     = tok_in.found | hit;
    tok_next.free_seen = tok_in.free_seen | free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid     <= 1'b0;
      pending        <= 1'b0;
      tok_out.active <= 1'b0;
    end else begin
      tok_out <= tok_next;
      if ((tok_in.op == BOP_REM) && hit && !tok_in.found) begin
        slot_valid <= 1'b0;
      end
      if ((tok_in.op == BOP_INS) && free && !tok_in.free_seen) begin
        pending <= 1'b1;
      end
      if (ctl.commit && pending) begin
        slot_valid <= 1'b1;
        slot_addr  <= wr_addr;
      end
      if (ctl.finish) begin
        pending <= 1'b0;
      end
    end
  end

endmodule

/* rtl/wbu_wch_cell.sv */
// One watchpoint slot of the watchpoint cell chain, with its range overlap compare.
// Depends on wbu_pkg for the token type.
module wbu_wch_cell
  import wbu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  wch_tok_t tok_in,
  output wch_tok_t tok_out
);

  logic [31:0] slot_start;
  logic [31:0] slot_len;
  logic        slot_on_w;
  logic        slot_on_r;
  logic        slot_valid;
  logic [31:0] slot_end;
  logic        same;
  logic        dir_ok;
  logic        overlap;
  logic        take;
  wch_tok_t    tok_next;

  always_comb begin
    slot_end = slot_start + slot_len;
    same     = slot_valid && (slot_start == tok_in.start) && (slot_len == tok_in.len) &&
               (slot_on_w == tok_in.on_w) && (slot_on_r == tok_in.on_r);
    dir_ok   = tok_in.is_wr ? slot_on_w : slot_on_r;
    overlap  = !(tok_in.acc_addr >= slot_end) && !(tok_in.acc_end <= slot_start);
    take     = 1'b0;
    if (tok_in.active && !tok_in.claimed) begin
      case (tok_in.op)
        WOP_INS: take = !slot_valid;
        WOP_REM: take = same;
        WOP_BUS: take = slot_valid && dir_ok && overlap;
        default: take = 1'b0;
      endcase
    end
    tok_next         = tok_in;
    tok_next.claimed = tok_in.claimed | take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid     <= 1'b0;
      tok_out.active <= 1'b0;
    end else begin
      tok_out <= tok_next;
      if (take && (tok_in.op == WOP_INS)) begin
        slot_valid <= 1'b1;
        slot_start <= tok_in.start;
        slot_len   <= tok_in.len;
        slot_on_w  <= tok_in.on_w;
        slot_on_r  <= tok_in.on_r;
      end
      if (take && (tok_in.op == WOP_REM)) begin
        slot_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/watchpoint_breakpoint_unit.sv */
// Watchpoint and breakpoint unit: top level with the sequencer and the two cell chains.
// Depends on wbu_pkg, wbu_stream_if, wbu_brk_cell and wbu_wch_cell.
// Each item's tokens walk both cell chains, one slot per cycle, and the result beat is
// loaded once both walks are done, so the longer cell chain sets when the result comes.
// A new item is taken only in idle, once the previous item's result has been loaded; an item may be taken
// while the previous result waits. Reset empties both tables and clears the hit record.
module watchpoint_breakpoint_unit
  import wbu_pkg::*;
#(
  parameter int BREAK_SLOTS = 8,
  parameter int WATCH_SLOTS = 8
) (
  input logic          clk,
  input logic          rst,
  wbu_stream_if.sink   req,
  wbu_stream_if.source rsp
);

  state_t      state;
  state_t      state_next;
  logic        accept;
  logic        load_out;
  in_item_t    item;
  logic [31:0] hold_addr;
  logic [1:0]  status_r;
  logic        at_bp_r;
  logic        bdone;
  logic        wdone;
  logic        hit_flag;
  logic        hit_read;
  logic [31:0] hit_addr;
  logic        out_valid;
  out_item_t   out_item;

  logic        is_brk;
  logic        is_wch;
  logic        is_pt_op;
  logic [2:0]  width;
  logic [1:0]  pre_status;
  brk_tok_t    brk_inj;
  wch_tok_t    wch_inj;
  brk_ctl_t    brk_ctl;
  logic        b_exit;
  logic        w_exit;

  brk_tok_t    btok [0:BREAK_SLOTS];
  wch_tok_t    wtok [0:WATCH_SLOTS];

  assign item   = req.payload;
  assign accept = req.valid && req.ready;

  always_comb begin
    is_brk   = item.point_type inside {PT_BREAK_SW, PT_BREAK_HW};
    is_wch   = item.point_type inside {PT_WRITE, PT_READ, PT_ACCESS};
    is_pt_op = (item.action == ACT_INSERT) || (item.action == ACT_REMOVE);
    case (item.access_bits)
      BITS_BYTE: width = 3'd1;
      BITS_HALF: width = 3'd2;
      BITS_WORD: width = 3'd4;
      default:   width = 3'd0;
    endcase
    pre_status = ST_OK;
    if (is_pt_op && is_wch && (item.point_length == 32'd0)) begin
      pre_status = ST_ZERO_LEN;
    end else if (is_pt_op && !is_brk && !is_wch) begin
      pre_status = ST_UNSUPPORTED;
    end

    brk_inj.active    = accept;
    brk_inj.found     = 1'b0;
    brk_inj.free_seen = 1'b0;
    brk_inj.addr      = item.point_address;
    brk_inj.op        = BOP_NOP;
    if (is_brk && (item.action == ACT_INSERT)) begin
      brk_inj.op = BOP_INS;
    end else if (is_brk && (item.action == ACT_REMOVE)) begin
      brk_inj.op = BOP_REM;
    end else if (item.action == ACT_PC) begin
      brk_inj.op   = BOP_CHK;
      brk_inj.addr = item.pc_value;
    end

    wch_inj.active   = accept;
    wch_inj.claimed  = 1'b0;
    wch_inj.start    = item.point_address;
    wch_inj.len      = item.point_length;
    wch_inj.on_w     = item.point_type inside {PT_WRITE, PT_ACCESS};
    wch_inj.on_r     = item.point_type inside {PT_READ, PT_ACCESS};
    wch_inj.acc_addr = item.access_address;
    wch_inj.acc_end  = item.access_address + {29'd0, width};
    wch_inj.is_wr    = item.is_write;
    wch_inj.op       = WOP_NOP;
    if (is_wch && (item.point_length != 32'd0) && (item.action == ACT_INSERT)) begin
      wch_inj.op = WOP_INS;
    end else if (is_wch && (item.point_length != 32'd0) && (item.action == ACT_REMOVE)) begin
      wch_inj.op = WOP_REM;
    end else if ((item.action == ACT_ACCESS) && !hit_flag && (width != 3'd0)) begin
      wch_inj.op = WOP_BUS;
    end
  end

  assign btok[0] = brk_inj;
  assign wtok[0] = wch_inj;

  for (genvar i = 0; i < BREAK_SLOTS; i++) begin : g_brk
    wbu_brk_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (btok[i]),
      .ctl     (brk_ctl),
      .wr_addr (hold_addr),
      .tok_out (btok[i+1])
    );
  end

  for (genvar i = 0; i < WATCH_SLOTS; i++) begin : g_wch
    wbu_wch_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (wtok[i]),
      .tok_out (wtok[i+1])
    );
  end

  assign b_exit = btok[BREAK_SLOTS].active;
  assign w_exit = wtok[WATCH_SLOTS].active;

  always_comb begin
    brk_ctl.finish = b_exit;
    brk_ctl.commit = b_exit && (btok[BREAK_SLOTS].op == BOP_INS) &&
                     !btok[BREAK_SLOTS].found && btok[BREAK_SLOTS].free_seen;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (bdone && wdone) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == S_IDLE);
    load_out  = (state == S_RESULT) && (!out_valid || rsp.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bdone     <= 1'b0;
      wdone     <= 1'b0;
      hit_flag  <= 1'b0;
      hit_read  <= 1'b0;
      hit_addr  <= 32'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        bdone     <= 1'b0;
        wdone     <= 1'b0;
        status_r  <= pre_status;
        at_bp_r   <= 1'b0;
        hold_addr <= item.point_address;
        if (item.action == ACT_CLEAR) begin
          hit_flag <= 1'b0;
          hit_read <= 1'b0;
          hit_addr <= 32'd0;
        end
      end
      if (b_exit) begin
        bdone <= 1'b1;
        if ((btok[BREAK_SLOTS].op == BOP_INS) && !btok[BREAK_SLOTS].found &&
            !btok[BREAK_SLOTS].free_seen) begin
          status_r <= ST_FULL;
        end
        if ((btok[BREAK_SLOTS].op == BOP_CHK) && btok[BREAK_SLOTS].found) begin
          at_bp_r <= 1'b1;
        end
      end
      if (w_exit) begin
        wdone <= 1'b1;
        if ((wtok[WATCH_SLOTS].op == WOP_INS) && !wtok[WATCH_SLOTS].claimed) begin
          status_r <= ST_FULL;
        end
        if ((wtok[WATCH_SLOTS].op == WOP_BUS) && wtok[WATCH_SLOTS].claimed) begin
          hit_flag <= 1'b1;
          hit_read <= !wtok[WATCH_SLOTS].is_wr;
          hit_addr <= wtok[WATCH_SLOTS].acc_addr;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item.status        <= status_r;
      out_item.at_breakpoint <= at_bp_r;
      out_item.hit_valid     <= hit_flag;
      out_item.hit_was_read  <= hit_read;
      out_item.hit_address   <= hit_addr;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_item;

endmodule
